### rtl/dvrt_pkg.sv
// Shared types and constants of the distance-vector route table.
// No dependencies; every other file but dvrt_ram takes names from here by scope.
package dvrt_pkg;

  // default configuration of the top level
  localparam int unsigned NODE_COUNT_DEF = 8;
  localparam int unsigned DIST_BITS_DEF  = 20;

  // fixed field widths of the channels
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned NODE_W     = 3;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned OUT_DIST_W = 20;

  // operations carried by an input item
  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD_LINK  = 2'd0,
    OP_SET_ENTRY = 2'd1,
    OP_RECOMPUTE = 2'd2
  } opcode_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK_RD,
    ST_LINK_WR,
    ST_SET_DIAG,
    ST_SET_WR,
    ST_NB_CHECK,
    ST_NB_COST,
    ST_D_RDNB,
    ST_D_RDOWN,
    ST_D_UPD,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

endpackage

### rtl/dvrt_cfg_if.sv
// Configuration write channel: valid/ready and the own node index.
// Depends on dvrt_pkg for the field width.
interface dvrt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dvrt_pkg::NODE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/dvrt_in_if.sv
// Input item channel: valid/ready plus opcode, nodes and weight.
// Depends on dvrt_pkg for the field widths.
interface dvrt_in_if;
  logic                          valid;
  logic                          ready;
  logic [dvrt_pkg::OPCODE_W-1:0] opcode;
  logic [dvrt_pkg::NODE_W-1:0]   src_node;
  logic [dvrt_pkg::NODE_W-1:0]   dest_node;
  logic [dvrt_pkg::WEIGHT_W-1:0] weight;

  modport source (output valid, output opcode, output src_node, output dest_node,
                  output weight, input ready);
  modport sink   (input valid, input opcode, input src_node, input dest_node,
                  input weight, output ready);
endinterface

### rtl/dvrt_out_if.sv
// Result item channel: valid/ready plus node, known, distance and last.
// Depends on dvrt_pkg for the field widths.
interface dvrt_out_if;
  logic                            valid;
  logic                            ready;
  logic [dvrt_pkg::NODE_W-1:0]     node;
  logic                            known;
  logic [dvrt_pkg::OUT_DIST_W-1:0] distance;
  logic                            last;

  modport source (output valid, output node, output known, output distance,
                  output last, input ready);
  modport sink   (input valid, input node, input known, input distance,
                  input last, output ready);
endinterface

### rtl/dvrt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dvrt_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/distance_vector_route_table_top.sv
// Distance-vector route table: cost table in one RAM, sequencer does read-modify-write.
// Add link is a read then a conditional write, set entry one or two writes; recompute runs
// relaxation passes over the neighbors (N = NODE_COUNT, one RAM read per step), passes repeat
// until stable, then one result per node is emitted. One item is worked on at a time.
// After reset and after every self_node write a clearing pass over all NODE_COUNT^2 cells runs;
// no item is taken during it. Depends on dvrt_pkg, the channel interfaces and dvrt_ram.
module distance_vector_route_table_top #(
  parameter int unsigned NODE_COUNT = dvrt_pkg::NODE_COUNT_DEF,
  parameter int unsigned DIST_BITS  = dvrt_pkg::DIST_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dvrt_cfg_if.sink   cfg_i,
  dvrt_in_if.sink    in_i,
  dvrt_out_if.source out_o
);

  localparam int unsigned IDX_W    = $clog2(NODE_COUNT);
  localparam int unsigned DEPTH    = NODE_COUNT * NODE_COUNT;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned WORD_W   = DIST_BITS + 1;
  localparam int unsigned EMIT_CNT = (NODE_COUNT < 8) ? NODE_COUNT : 8;
  localparam int unsigned EMIT_W   = $clog2(EMIT_CNT);

  localparam logic [IDX_W-1:0]                LAST_IDX  = IDX_W'(NODE_COUNT - 1);
  localparam logic [ADDR_W-1:0]               LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [EMIT_W-1:0]               LAST_EMIT = EMIT_W'(EMIT_CNT - 1);
  localparam logic [DIST_BITS-1:0]            DMAX      = '1;
  localparam logic [dvrt_pkg::OUT_DIST_W-1:0] OUT_MAX   = '1;

  // table cell address of row, column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(NODE_COUNT) + ADDR_W'(col);
  endfunction

  // control state
  dvrt_pkg::state_e              state_q, state_d;
  logic [dvrt_pkg::NODE_W-1:0]   self_q, self_d;
  logic [ADDR_W-1:0]             clr_q, clr_d;
  logic [NODE_COUNT-1:0]         nbr_q, nbr_d;
  logic [NODE_COUNT-1:0]         row_q, row_d;
  logic                          change_q, change_d;
  logic [IDX_W-1:0]              nb_q, nb_d;
  logic [IDX_W-1:0]              d_q, d_d;
  logic [EMIT_W-1:0]             emit_q, emit_d;
  logic                          out_valid_q;

  // latched item fields and working values
  logic [IDX_W-1:0]              src_q, src_d;
  logic [IDX_W-1:0]              dst_q, dst_d;
  logic [DIST_BITS-1:0]          w_q, w_d;
  logic [DIST_BITS-1:0]          nbcost_q, nbcost_d;
  logic [DIST_BITS-1:0]          sum_q, sum_d;

  // result register
  logic [dvrt_pkg::NODE_W-1:0]   out_node_q;
  logic                          out_known_q;
  logic [dvrt_pkg::OUT_DIST_W-1:0] out_dist_q;
  logic                          out_last_q;
  logic                          out_load;
  logic                          out_free;

  // RAM ports
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_waddr;
  logic [WORD_W-1:0]             mem_wdata;
  logic                          mem_re;
  logic [ADDR_W-1:0]             mem_raddr;
  logic [WORD_W-1:0]             mem_rdata;
  logic                          rd_known;
  logic [DIST_BITS-1:0]          rd_cost;

  // decoded helpers
  logic                          in_fire;
  logic                          cfg_fire;
  logic                          self_ok;
  logic [IDX_W-1:0]              self_idx;
  logic [ADDR_W-1:0]             diag_addr;
  logic                          src_in_ok;
  logic                          dst_in_ok;
  logic [IDX_W-1:0]              src_in;
  logic [IDX_W-1:0]              dst_in;
  logic [31:0]                   w_ext;
  logic [DIST_BITS-1:0]          w_clamp;
  logic [DIST_BITS:0]            sum_full;
  logic [DIST_BITS-1:0]          sum_sat;
  logic                          relax_upd;
  logic                          nb_more;
  logic                          nb_last;
  logic                          d_last;
  logic [NODE_COUNT-1:0]         cfg_row_init;
  logic [31:0]                   rd_cost_ext;
  logic [dvrt_pkg::OUT_DIST_W-1:0] rd_cost_out;

  dvrt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_known = mem_rdata[DIST_BITS];
  assign rd_cost  = mem_rdata[DIST_BITS-1:0];

  // handshakes
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign in_i.ready  = (state_q == dvrt_pkg::ST_IDLE) && !cfg_i.valid;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  // node index checks and narrowing
  assign self_ok   = 32'(self_q) < NODE_COUNT;
  assign self_idx  = IDX_W'(self_q);
  assign diag_addr = cell_addr(self_idx, self_idx);
  assign src_in_ok = 32'(in_i.src_node) < NODE_COUNT;
  assign dst_in_ok = 32'(in_i.dest_node) < NODE_COUNT;
  assign src_in    = IDX_W'(in_i.src_node);
  assign dst_in    = IDX_W'(in_i.dest_node);

  assign cfg_row_init = (32'(cfg_i.data) < NODE_COUNT) ?
                        (NODE_COUNT'(1) << cfg_i.data) : '0;

  // weight clamp to the table range
  assign w_ext   = 32'(in_i.weight);
  assign w_clamp = (w_ext > 32'(DMAX)) ? DMAX : DIST_BITS'(w_ext);

  // saturating path sum: neighbor cost plus neighbor row entry
  assign sum_full = {1'b0, nbcost_q} + {1'b0, rd_cost};
  assign sum_sat  = sum_full[DIST_BITS] ? DMAX : sum_full[DIST_BITS-1:0];

  // own entry is taken when unknown or strictly worse
  assign relax_upd = (state_q == dvrt_pkg::ST_D_UPD) && (!rd_known || (sum_q < rd_cost));
  assign nb_more   = change_q || relax_upd;
  assign nb_last   = nb_q == LAST_IDX;
  assign d_last    = d_q == LAST_IDX;

  // result distance saturated to the output width
  assign rd_cost_ext = 32'(rd_cost);
  assign rd_cost_out = (rd_cost_ext > 32'(OUT_MAX)) ? OUT_MAX :
                       rd_cost_ext[dvrt_pkg::OUT_DIST_W-1:0];

  // sequencer: next state, RAM accesses, result load
  always_comb begin
    state_d   = state_q;
    self_d    = self_q;
    clr_d     = clr_q;
    nbr_d     = nbr_q;
    row_d     = row_q;
    change_d  = change_q;
    nb_d      = nb_q;
    d_d       = d_q;
    emit_d    = emit_q;
    src_d     = src_q;
    dst_d     = dst_q;
    w_d       = w_q;
    nbcost_d  = nbcost_q;
    sum_d     = sum_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;

    case (state_q)
      dvrt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {self_ok && (clr_q == diag_addr), {DIST_BITS{1'b0}}};
        if (clr_q == LAST_ADDR) begin
          state_d = dvrt_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      dvrt_pkg::ST_IDLE: begin
        if (in_fire) begin
          src_d = src_in;
          dst_d = dst_in;
          w_d   = w_clamp;
          case (dvrt_pkg::opcode_e'(in_i.opcode))
            dvrt_pkg::OP_ADD_LINK: begin
              if (self_ok && dst_in_ok && !nbr_q[dst_in]) begin
                nbr_d[dst_in] = 1'b1;
                state_d       = dvrt_pkg::ST_LINK_RD;
              end
            end
            dvrt_pkg::OP_SET_ENTRY: begin
              if (src_in_ok && dst_in_ok) begin
                if (!row_q[src_in]) begin
                  row_d[src_in] = 1'b1;
                  state_d       = dvrt_pkg::ST_SET_DIAG;
                end else begin
                  state_d = dvrt_pkg::ST_SET_WR;
                end
              end
            end
            dvrt_pkg::OP_RECOMPUTE: begin
              if (self_ok) begin
                nb_d     = '0;
                change_d = 1'b0;
                state_d  = dvrt_pkg::ST_NB_CHECK;
              end else begin
                emit_d  = '0;
                state_d = dvrt_pkg::ST_EMIT_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // add link: enter weight only if own entry is still unknown
      dvrt_pkg::ST_LINK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr(self_idx, dst_q);
        state_d   = dvrt_pkg::ST_LINK_WR;
      end

      dvrt_pkg::ST_LINK_WR: begin
        if (!rd_known) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(self_idx, dst_q);
          mem_wdata = {1'b1, w_q};
        end
        state_d = dvrt_pkg::ST_IDLE;
      end

      // new row: diagonal first, then the advertised cost unless it is the diagonal itself
      dvrt_pkg::ST_SET_DIAG: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(src_q, src_q);
        mem_wdata = {1'b1, {DIST_BITS{1'b0}}};
        state_d   = (dst_q != src_q) ? dvrt_pkg::ST_SET_WR : dvrt_pkg::ST_IDLE;
      end

      dvrt_pkg::ST_SET_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(src_q, dst_q);
        mem_wdata = {1'b1, w_q};
        state_d   = dvrt_pkg::ST_IDLE;
      end

      // relaxation: fetch own cost to the neighbor
      dvrt_pkg::ST_NB_CHECK: begin
        if (nbr_q[nb_q] && row_q[nb_q]) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(self_idx, nb_q);
          state_d   = dvrt_pkg::ST_NB_COST;
        end else if (nb_last) begin
          change_d = 1'b0;
          nb_d     = '0;
          emit_d   = '0;
          state_d  = nb_more ? dvrt_pkg::ST_NB_CHECK : dvrt_pkg::ST_EMIT_RD;
        end else begin
          nb_d    = nb_q + 1'b1;
          state_d = dvrt_pkg::ST_NB_CHECK;
        end
      end

      dvrt_pkg::ST_NB_COST: begin
        if (rd_known) begin
          nbcost_d = rd_cost;
          d_d      = '0;
          state_d  = dvrt_pkg::ST_D_RDNB;
        end else if (nb_last) begin
          change_d = 1'b0;
          nb_d     = '0;
          emit_d   = '0;
          state_d  = nb_more ? dvrt_pkg::ST_NB_CHECK : dvrt_pkg::ST_EMIT_RD;
        end else begin
          nb_d    = nb_q + 1'b1;
          state_d = dvrt_pkg::ST_NB_CHECK;
        end
      end

      // neighbor row entry, then own row entry of the same column
      dvrt_pkg::ST_D_RDNB: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr(nb_q, d_q);
        state_d   = dvrt_pkg::ST_D_RDOWN;
      end

      dvrt_pkg::ST_D_RDOWN: begin
        if (rd_known) begin
          sum_d     = sum_sat;
          mem_re    = 1'b1;
          mem_raddr = cell_addr(self_idx, d_q);
          state_d   = dvrt_pkg::ST_D_UPD;
        end else if (!d_last) begin
          d_d     = d_q + 1'b1;
          state_d = dvrt_pkg::ST_D_RDNB;
        end else if (nb_last) begin
          change_d = 1'b0;
          nb_d     = '0;
          emit_d   = '0;
          state_d  = nb_more ? dvrt_pkg::ST_NB_CHECK : dvrt_pkg::ST_EMIT_RD;
        end else begin
          nb_d    = nb_q + 1'b1;
          state_d = dvrt_pkg::ST_NB_CHECK;
        end
      end

      dvrt_pkg::ST_D_UPD: begin
        change_d = nb_more;
        if (relax_upd) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(self_idx, d_q);
          mem_wdata = {1'b1, sum_q};
        end
        if (!d_last) begin
          d_d     = d_q + 1'b1;
          state_d = dvrt_pkg::ST_D_RDNB;
        end else if (nb_last) begin
          change_d = 1'b0;
          nb_d     = '0;
          emit_d   = '0;
          state_d  = nb_more ? dvrt_pkg::ST_NB_CHECK : dvrt_pkg::ST_EMIT_RD;
        end else begin
          nb_d    = nb_q + 1'b1;
          state_d = dvrt_pkg::ST_NB_CHECK;
        end
      end

      // report own row, one result per node (at most eight)
      dvrt_pkg::ST_EMIT_RD: begin
        mem_re    = self_ok;
        mem_raddr = cell_addr(self_idx, IDX_W'(emit_q));
        state_d   = dvrt_pkg::ST_EMIT_WR;
      end

      dvrt_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          if (emit_q == LAST_EMIT) begin
            state_d = dvrt_pkg::ST_IDLE;
          end else begin
            emit_d  = emit_q + 1'b1;
            state_d = dvrt_pkg::ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = dvrt_pkg::ST_IDLE;
      end
    endcase

    // own node write restarts the table
    if (cfg_fire) begin
      self_d  = cfg_i.data;
      clr_d   = '0;
      nbr_d   = '0;
      row_d   = cfg_row_init;
      state_d = dvrt_pkg::ST_CLEAR;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dvrt_pkg::ST_CLEAR;
      self_q      <= '0;
      clr_q       <= '0;
      nbr_q       <= '0;
      row_q       <= NODE_COUNT'(1);
      change_q    <= 1'b0;
      nb_q        <= '0;
      d_q         <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      self_q   <= self_d;
      clr_q    <= clr_d;
      nbr_q    <= nbr_d;
      row_q    <= row_d;
      change_q <= change_d;
      nb_q     <= nb_d;
      d_q      <= d_d;
      emit_q   <= emit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    dst_q    <= dst_d;
    w_q      <= w_d;
    nbcost_q <= nbcost_d;
    sum_q    <= sum_d;
    if (out_load) begin
      out_node_q  <= dvrt_pkg::NODE_W'(emit_q);
      out_known_q <= self_ok && rd_known;
      out_dist_q  <= (self_ok && rd_known) ? rd_cost_out : '0;
      out_last_q  <= emit_q == LAST_EMIT;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.node     = out_node_q;
  assign out_o.known    = out_known_q;
  assign out_o.distance = out_dist_q;
  assign out_o.last     = out_last_q;

endmodule

### verif/tb.sv
// Self-checking bench for distance_vector_route_table_top: directed rows, then random traffic.
// Depends on dvrt_pkg, the three channel interfaces and the top level of the RTL.
module tb;

  localparam int unsigned NODES          = dvrt_pkg::NODE_COUNT_DEF;
  localparam int unsigned DIST_W         = dvrt_pkg::DIST_BITS_DEF;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [dvrt_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned TAIL_CYCLES    = 50;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned PHASE_ITEMS    = 80;

  typedef struct packed {
    logic [dvrt_pkg::NODE_W-1:0]     node;
    logic                            known;
    logic [dvrt_pkg::OUT_DIST_W-1:0] distance;
    logic                            last;
  } route_rsp_t;

  // hand-typed recompute result: distances are either 0 or the full 16-bit weight
  typedef struct packed {
    logic [7:0] known_mask;
    logic [7:0] full_mask;
  } fixed_row_t;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_e;

  typedef struct packed {
    step_kind_e                    kind;
    logic [dvrt_pkg::OPCODE_W-1:0] op;
    logic [dvrt_pkg::NODE_W-1:0]   src;
    logic [dvrt_pkg::NODE_W-1:0]   dst;
    logic [dvrt_pkg::WEIGHT_W-1:0] weight;
    logic                          typed;
    fixed_row_t                    fixed;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dvrt_cfg_if cfg_ch ();
  dvrt_in_if  item_ch ();
  dvrt_out_if route_ch ();

  distance_vector_route_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (item_ch),
    .out_o  (route_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow route table
  logic [dvrt_pkg::NODE_W-1:0] own_node;
  logic [DIST_W-1:0] link_cost [NODES*NODES];
  logic              cost_known [NODES*NODES];
  logic              row_seen [NODES];
  logic              is_neighbor [NODES];

  route_rsp_t  pending_routes [$];
  fixed_row_t  fixed_rows [$];
  plan_row_t   directed_plan [$];
  int unsigned errors = 0;
  int unsigned routes_seen = 0;
  int unsigned stall_cycles = 0;

  function automatic void reload_table(logic [dvrt_pkg::NODE_W-1:0] self_idx);
    own_node = self_idx;
    for (int i = 0; i < NODES*NODES; i++) begin
      link_cost[i]  = '0;
      cost_known[i] = 1'b0;
    end
    for (int i = 0; i < NODES; i++) begin
      row_seen[i]    = 1'b0;
      is_neighbor[i] = 1'b0;
    end
    row_seen[self_idx] = 1'b1;
    cost_known[self_idx*NODES + self_idx] = 1'b1;
  endfunction

  // relax own row through neighbor rows until a full pass changes nothing
  function automatic void settle_own_row();
    int unsigned base;
    int unsigned own_idx;
    logic [DIST_W-1:0] via_cost;
    logic [DIST_W:0]   sum;
    bit changed;
    base = own_node * NODES;
    do begin
      changed = 1'b0;
      for (int nb = 0; nb < NODES; nb++) begin
        if (!is_neighbor[nb] || !row_seen[nb] || !cost_known[base+nb]) continue;
        via_cost = link_cost[base+nb];
        for (int d = 0; d < NODES; d++) begin
          if (!cost_known[nb*NODES + d]) continue;
          sum = {1'b0, via_cost} + {1'b0, link_cost[nb*NODES + d]};
          if (sum > {1'b0, DIST_MAX}) sum = {1'b0, DIST_MAX};
          own_idx = base + d;
          if (!cost_known[own_idx] || sum[DIST_W-1:0] < link_cost[own_idx]) begin
            cost_known[own_idx] = 1'b1;
            link_cost[own_idx]  = sum[DIST_W-1:0];
            changed = 1'b1;
          end
        end
      end
    end while (changed);
  endfunction

  // apply one accepted item to the shadow table; recompute queues its 8 routes
  function automatic void predict_item(logic [dvrt_pkg::OPCODE_W-1:0] op,
                                       logic [dvrt_pkg::NODE_W-1:0] src,
                                       logic [dvrt_pkg::NODE_W-1:0] dst,
                                       logic [dvrt_pkg::WEIGHT_W-1:0] w);
    int unsigned own_idx;
    route_rsp_t rsp;
    fixed_row_t fx;
    bit use_fixed;
    case (op)
      dvrt_pkg::OP_ADD_LINK: begin
        if (!is_neighbor[dst]) begin
          is_neighbor[dst] = 1'b1;
          own_idx = own_node*NODES + dst;
          if (!cost_known[own_idx]) begin
            cost_known[own_idx] = 1'b1;
            link_cost[own_idx]  = DIST_W'(w);
          end
        end
      end
      dvrt_pkg::OP_SET_ENTRY: begin
        if (!row_seen[src]) begin
          // new row: diagonal 0, a self entry does not overwrite it
          row_seen[src] = 1'b1;
          cost_known[src*NODES + src] = 1'b1;
          link_cost[src*NODES + src]  = '0;
          if (dst != src) begin
            cost_known[src*NODES + dst] = 1'b1;
            link_cost[src*NODES + dst]  = DIST_W'(w);
          end
        end else begin
          cost_known[src*NODES + dst] = 1'b1;
          link_cost[src*NODES + dst]  = DIST_W'(w);
        end
      end
      dvrt_pkg::OP_RECOMPUTE: begin
        settle_own_row();
        use_fixed = (fixed_rows.size() != 0);
        if (use_fixed) fx = fixed_rows.pop_front();
        for (int n = 0; n < NODES; n++) begin
          rsp.node = dvrt_pkg::NODE_W'(n);
          rsp.last = (n == NODES-1);
          if (use_fixed) begin
            rsp.known    = fx.known_mask[n];
            rsp.distance = fx.full_mask[n] ? dvrt_pkg::OUT_DIST_W'(16'hFFFF) : '0;
          end else begin
            rsp.known    = cost_known[own_node*NODES + n];
            rsp.distance = rsp.known ?
                           dvrt_pkg::OUT_DIST_W'(link_cost[own_node*NODES + n]) : '0;
          end
          pending_routes.push_back(rsp);
        end
      end
      default: ;  // unused opcode: no effect
    endcase
  endfunction

  initial reload_table('0);

  // track accepted config writes and items
  always @(posedge clk_i) begin
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) reload_table(cfg_ch.data);
    if (rst_ni && item_ch.valid && item_ch.ready)
      predict_item(item_ch.opcode, item_ch.src_node, item_ch.dest_node, item_ch.weight);
  end

  // compare each accepted route with the oldest expectation
  always @(posedge clk_i) begin : route_check
    route_rsp_t want;
    if (rst_ni && route_ch.valid && route_ch.ready) begin
      routes_seen++;
      if (pending_routes.size() == 0) begin
        $error("unexpected route: node %0d known %0d distance %0d", route_ch.node,
               route_ch.known, route_ch.distance);
        errors++;
      end else begin
        want = pending_routes.pop_front();
        if (route_ch.node !== want.node) begin
          $error("node: expected %0d, got %0d", want.node, route_ch.node);
          errors++;
        end
        if (route_ch.known !== want.known) begin
          $error("known: expected %0d, got %0d", want.known, route_ch.known);
          errors++;
        end
        if (route_ch.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, route_ch.distance);
          errors++;
        end
        if (route_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, route_ch.last);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready) ||
        (route_ch.valid && route_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  // small weights so relaxation finds shorter paths, some full range
  function automatic logic [dvrt_pkg::WEIGHT_W-1:0] random_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return dvrt_pkg::WEIGHT_W'($urandom_range(0, 40));
    if (r < 85) return dvrt_pkg::WEIGHT_W'($urandom_range(0, 2000));
    if (r < 90) return (r[0]) ? 16'hFFFF : 16'h0000;
    return dvrt_pkg::WEIGHT_W'($urandom_range(0, 65535));
  endfunction

  // route receiver: random ready, one long hold-off once traffic is flowing
  initial begin : route_sink
    int unsigned run_len;
    int unsigned gap;
    bit held;
    held = 1'b0;
    route_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      route_ch.ready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      repeat (run_len) @(posedge clk_i);
      if (!held && routes_seen >= 120) begin
        held = 1'b1;
        route_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          route_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  task automatic offer_item(input logic [dvrt_pkg::OPCODE_W-1:0] op,
                            input logic [dvrt_pkg::NODE_W-1:0] src,
                            input logic [dvrt_pkg::NODE_W-1:0] dst,
                            input logic [dvrt_pkg::WEIGHT_W-1:0] w,
                            input int unsigned gap);
    item_ch.valid     <= 1'b1;
    item_ch.opcode    <= op;
    item_ch.src_node  <= src;
    item_ch.dest_node <= dst;
    item_ch.weight    <= w;
    do @(posedge clk_i); while (!(item_ch.valid && item_ch.ready));
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_routes_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_routes.size() != 0);
  endtask

  // own node changes only while idle; the block may still finish a table write
  task automatic write_self_node(input logic [dvrt_pkg::NODE_W-1:0] self_idx);
    wait_routes_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_ch.data  <= self_idx;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void plan(step_kind_e kind, logic [dvrt_pkg::OPCODE_W-1:0] op,
                               logic [dvrt_pkg::NODE_W-1:0] src,
                               logic [dvrt_pkg::NODE_W-1:0] dst,
                               logic [dvrt_pkg::WEIGHT_W-1:0] w, logic typed,
                               logic [7:0] known_mask, logic [7:0] full_mask);
    plan_row_t row;
    row.kind   = kind;
    row.op     = op;
    row.src    = src;
    row.dst    = dst;
    row.weight = w;
    row.typed  = typed;
    row.fixed  = '{known_mask: known_mask, full_mask: full_mask};
    directed_plan.push_back(row);
  endfunction

  task automatic run_random_phase(input int unsigned count, input bit no_gaps);
    int unsigned sent;
    int unsigned pick;
    logic [dvrt_pkg::OPCODE_W-1:0] op;
    logic [dvrt_pkg::NODE_W-1:0]   src;
    logic [dvrt_pkg::NODE_W-1:0]   dst;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      src  = dvrt_pkg::NODE_W'($urandom_range(0, NODES-1));
      dst  = dvrt_pkg::NODE_W'($urandom_range(0, NODES-1));
      if (pick < 25)      op = dvrt_pkg::OP_ADD_LINK;
      else if (pick < 70) op = dvrt_pkg::OP_SET_ENTRY;
      else if (pick < 95) op = dvrt_pkg::OP_RECOMPUTE;
      else                op = OP_UNUSED;
      if (op != OP_UNUSED) sent++;
      offer_item(op, src, dst, random_weight(), no_gaps ? 0 : pick_gap());
      // sender pause until every route is back
      if (op != OP_UNUSED && sent == count/2) wait_routes_drained();
    end
  endtask

  initial begin : stimulus
    plan_row_t row;
    rst_ni = 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    item_ch.valid     <= 1'b0;
    item_ch.opcode    <= dvrt_pkg::OP_ADD_LINK;
    item_ch.src_node  <= '0;
    item_ch.dest_node <= '0;
    item_ch.weight    <= '0;

    // own node 0 after reset
    plan(STEP_ITEM, dvrt_pkg::OP_RECOMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 8'h01, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_ADD_LINK,  3'd0, 3'd7, 16'hFFFF, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_RECOMPUTE, 3'd7, 3'd7, 16'hFFFF, 1'b1, 8'h81, 8'h80);
    // already a neighbor
    plan(STEP_ITEM, dvrt_pkg::OP_ADD_LINK,  3'd0, 3'd7, 16'h0005, 1'b0, 8'h00, 8'h00);
    // new row
    plan(STEP_ITEM, dvrt_pkg::OP_SET_ENTRY, 3'd7, 3'd3, 16'h0000, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_RECOMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 8'h89, 8'h88);
    // overwrite diagonal
    plan(STEP_ITEM, dvrt_pkg::OP_SET_ENTRY, 3'd7, 3'd7, 16'h000A, 1'b0, 8'h00, 8'h00);
    // cost already known
    plan(STEP_ITEM, dvrt_pkg::OP_ADD_LINK,  3'd0, 3'd3, 16'h0064, 1'b0, 8'h00, 8'h00);
    // new row on diagonal
    plan(STEP_ITEM, dvrt_pkg::OP_SET_ENTRY, 3'd2, 3'd2, 16'h0309, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_ADD_LINK,  3'd0, 3'd2, 16'h0001, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_SET_ENTRY, 3'd2, 3'd6, 16'hFFFF, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_SET_ENTRY, 3'd3, 3'd5, 16'h0000, 1'b0, 8'h00, 8'h00);
    // link to itself
    plan(STEP_ITEM, dvrt_pkg::OP_ADD_LINK,  3'd0, 3'd0, 16'h0009, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, OP_UNUSED,              3'd5, 3'd2, 16'hAAAA, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_RECOMPUTE, 3'd0, 3'd0, 16'h5555, 1'b0, 8'h00, 8'h00);
    // higher cost advertised
    plan(STEP_ITEM, dvrt_pkg::OP_SET_ENTRY, 3'd7, 3'd3, 16'hFFFF, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_RECOMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00);
    // own node 7: table starts over
    plan(STEP_CFG,  dvrt_pkg::OP_ADD_LINK,  3'd7, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_RECOMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 8'h80, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_ADD_LINK,  3'd0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_SET_ENTRY, 3'd0, 3'd7, 16'hFFFF, 1'b0, 8'h00, 8'h00);
    plan(STEP_ITEM, dvrt_pkg::OP_RECOMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 8'h81, 8'h00);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == STEP_CFG) begin
        write_self_node(row.src);
      end else begin
        if (row.typed) fixed_rows.push_back(row.fixed);
        offer_item(row.op, row.src, row.dst, row.weight, pick_gap());
      end
    end

    // random traffic under several own nodes, one phase without input gaps
    write_self_node(3'd3);
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_self_node(3'd4);
    run_random_phase(PHASE_ITEMS, 1'b1);
    write_self_node(3'd0);
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_self_node(3'd7);
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_self_node(dvrt_pkg::NODE_W'($urandom_range(0, NODES-1)));
    run_random_phase(PHASE_ITEMS, 1'b0);

    wait_routes_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
